// ----- hdl/pmi_pkg.sv -----
// ----------------------------------------------------------------------------
// Palindrome minimum-insertion package
// Shared widths, defaults and payload types of the palindrome core.
// ----------------------------------------------------------------------------
package pmi_pkg;

  localparam int unsigned PMI_MAX_LEN = 32;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned COST_W      = 5;

  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [COST_W-1:0] cost_t;

endpackage

// ----- hdl/pmi_cost_table.sv -----
// ----------------------------------------------------------------------------
// Palindrome cost table
// Interval cost memory with two registered read ports and the cell update
// stage that fills it one cell per cycle.
// ----------------------------------------------------------------------------
module pmi_cost_table import pmi_pkg::*; #(
  parameter int unsigned MAX_LEN = PMI_MAX_LEN
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       fill_i,
  input  logic [$clog2(MAX_LEN)-1:0] row_i,
  input  logic [$clog2(MAX_LEN)-1:0] col_i,
  input  logic                       same_i,
  output cost_t                      cell_c_o,
  output cost_t                      cell_d_o,
  output cost_t                      cell_val_o,
  output logic                       cell_wr_o
);

  localparam int unsigned IW = $clog2(MAX_LEN);
  localparam int unsigned AW = 2 * IW;
  localparam int unsigned CDepth = 1 << AW;

  cost_t cost_mem [CDepth];

  logic [IW-1:0] row_p1;
  logic [IW-1:0] col_m1;
  logic [AW-1:0] addr_c;
  logic [AW-1:0] addr_d;
  cost_t         rd_c_q;
  cost_t         rd_d_q;

  logic          s1_valid_q;
  logic [IW-1:0] s1_row_q;
  logic [IW-1:0] s1_col_q;
  cost_t         v_prev_q;

  logic [IW:0]   row_e;
  logic [IW:0]   col_e;
  logic          diag_zero;
  logic          adj;
  cost_t         c_diag;
  cost_t         c_down;
  cost_t         c_left;
  cost_t         c_min;
  cost_t         cell_val;

  assign row_p1 = row_i + 1'b1;
  assign col_m1 = col_i - 1'b1;
  assign addr_c = fill_i ? {row_p1, col_m1} : {row_i, col_i};
  assign addr_d = {row_p1, col_i};

  // Cells on or below the diagonal read as zero.
  assign row_e     = {1'b0, s1_row_q};
  assign col_e     = {1'b0, s1_col_q};
  assign diag_zero = (col_e <= row_e + (IW+1)'(2));
  assign adj       = (col_e == row_e + (IW+1)'(1));
  assign c_diag    = diag_zero ? '0 : rd_c_q;
  assign c_down    = adj ? '0 : rd_d_q;
  assign c_left    = adj ? '0 : v_prev_q;
  assign c_min     = (c_down < c_left) ? c_down : c_left;
  assign cell_val  = same_i ? c_diag : cost_t'(c_min + 1'b1);

  always_ff @(posedge clk_i) begin
    rd_c_q <= cost_mem[addr_c];
    rd_d_q <= cost_mem[addr_d];
    if (s1_valid_q) begin
      cost_mem[{s1_row_q, s1_col_q}] <= cell_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= fill_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_row_q <= row_i;
    s1_col_q <= col_i;
    if (s1_valid_q) begin
      v_prev_q <= cell_val;
    end
  end

  assign cell_c_o   = rd_c_q;
  assign cell_d_o   = rd_d_q;
  assign cell_val_o = cell_val;
  assign cell_wr_o  = s1_valid_q;

  a_cell_above_diag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> (s1_row_q < s1_col_q))
    else $error("cost cell written on or below the diagonal");

endmodule

// ----- hdl/palindrome_min_insertion_dp_core.sv -----
// ----------------------------------------------------------------------------
// Palindrome minimum-insertion core
// Loads a word byte by byte, fills the interval cost table and streams out
// the shortest palindrome formed by inserting letters.
//
//   Channel  Direction  Handshake                 Payload
//   in       input      in_valid_i / in_stall_o   char_in_i, word_end_i
//   out      output     out_valid_o / out_stall_i char_out_o, insert_count_o,
//                                                 run_end_o, overflowed_o
//
// A byte without the end mark is taken and the core keeps loading.
// For a word of n >= 2 bytes the table fill writes one cell per cycle,
// limited by the single write port of the cost memory.
// Each palindrome character then takes a memory read step and an emit step.
// Reset is asynchronous; the word, cost and stack memories are not cleared.
// An output stall only holds the current transaction and pauses the walk.
// ----------------------------------------------------------------------------
module palindrome_min_insertion_dp_core import pmi_pkg::*; #(
  parameter int unsigned MAX_LEN = PMI_MAX_LEN
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  char_t char_in_i,
  input  logic  word_end_i,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  output char_t char_out_o,
  output cost_t insert_count_o,
  output logic  run_end_o,
  output logic  overflowed_o
);

  localparam int unsigned IW = $clog2(MAX_LEN);
  localparam int unsigned LW = $clog2(MAX_LEN + 1);
  localparam logic [LW-1:0] LenMax = LW'(MAX_LEN);

  localparam logic [2:0] S_LOAD     = 3'd0;
  localparam logic [2:0] S_FILL     = 3'd1;
  localparam logic [2:0] S_FILL_END = 3'd2;
  localparam logic [2:0] S_WALK_RD  = 3'd3;
  localparam logic [2:0] S_WALK_EV  = 3'd4;
  localparam logic [2:0] S_BACK_RD  = 3'd5;
  localparam logic [2:0] S_BACK_EV  = 3'd6;

  logic [2:0]    state_q, state_d;
  logic [LW-1:0] len_q, len_d;
  logic          ovf_q, ovf_d;
  logic [IW-1:0] row_q, row_d;
  logic [IW-1:0] col_q, col_d;
  logic [IW-1:0] sp_q, sp_d;
  cost_t         ins_q, ins_d;

  logic          out_valid_q, out_valid_d;
  char_t         out_char_q, out_char_d;
  cost_t         out_ins_q, out_ins_d;
  logic          out_end_q, out_end_d;
  logic          out_ovf_q, out_ovf_d;

  char_t         word_mem [MAX_LEN];
  char_t         stk_mem [MAX_LEN];
  char_t         wa_q;
  char_t         wb_q;
  char_t         stk_rd_q;

  logic          in_accept;
  logic          room;
  logic [LW-1:0] len_new;
  logic          slot_free;
  logic [IW-1:0] n_last;
  logic          same;
  logic          adj_walk;
  cost_t         cell_c;
  cost_t         cell_d;
  cost_t         cell_val;
  logic          cell_wr;
  cost_t         walk_down;
  logic          take_left;
  char_t         walk_char;
  logic          word_we;
  logic          stk_we;
  logic          emit;
  char_t         emit_char;
  logic          emit_end;

  assign in_accept = in_valid_i && (state_q == S_LOAD);
  assign in_stall_o = (state_q != S_LOAD);
  assign room      = (len_q < LenMax);
  assign len_new   = room ? (len_q + 1'b1) : len_q;
  assign slot_free = !out_valid_q || !out_stall_i;
  assign n_last    = IW'(len_q - 1'b1);
  assign same      = (wa_q == wb_q);
  assign adj_walk  = (({1'b0, row_q} + (IW+1)'(1)) == {1'b0, col_q});
  assign walk_down = adj_walk ? '0 : cell_d;
  assign take_left = ({1'b0, cell_c} == ({1'b0, walk_down} + 6'd1));
  assign walk_char = (same || take_left) ? wa_q : wb_q;

  pmi_cost_table #(
    .MAX_LEN(MAX_LEN)
  ) u_cost_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fill_i    (state_q == S_FILL),
    .row_i     (row_q),
    .col_i     (col_q),
    .same_i    (same),
    .cell_c_o  (cell_c),
    .cell_d_o  (cell_d),
    .cell_val_o(cell_val),
    .cell_wr_o (cell_wr)
  );

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    ovf_d       = ovf_q;
    row_d       = row_q;
    col_d       = col_q;
    sp_d        = sp_q;
    ins_d       = ins_q;
    word_we     = 1'b0;
    stk_we      = 1'b0;
    emit        = 1'b0;
    emit_char   = wa_q;
    emit_end    = 1'b0;

    if (cell_wr) begin
      ins_d = cell_val;
    end

    case (state_q)
      S_LOAD: begin
        if (in_accept) begin
          word_we = room;
          len_d   = len_new;
          if (!room) begin
            ovf_d = 1'b1;
          end
          if (word_end_i) begin
            ins_d = '0;
            sp_d  = '0;
            if (len_new == LW'(1)) begin
              row_d   = '0;
              col_d   = '0;
              state_d = S_WALK_RD;
            end else begin
              row_d   = IW'(len_new - LW'(2));
              col_d   = IW'(len_new - LW'(1));
              state_d = S_FILL;
            end
          end
        end
      end
      S_FILL: begin
        if (col_q == n_last) begin
          if (row_q == '0) begin
            state_d = S_FILL_END;
          end else begin
            row_d = row_q - 1'b1;
            col_d = row_q;
          end
        end else begin
          col_d = col_q + 1'b1;
        end
      end
      S_FILL_END: begin
        row_d   = '0;
        col_d   = n_last;
        state_d = S_WALK_RD;
      end
      S_WALK_RD: begin
        state_d = S_WALK_EV;
      end
      S_WALK_EV: begin
        if (slot_free) begin
          emit = 1'b1;
          if (row_q == col_q) begin
            emit_char = wa_q;
            emit_end  = (sp_q == '0);
            if (sp_q == '0) begin
              state_d = S_LOAD;
              len_d   = '0;
              ovf_d   = 1'b0;
            end else begin
              state_d = S_BACK_RD;
            end
          end else begin
            emit_char = walk_char;
            stk_we    = 1'b1;
            sp_d      = sp_q + 1'b1;
            state_d   = S_WALK_RD;
            if (same) begin
              row_d = row_q + 1'b1;
              col_d = col_q - 1'b1;
              if (adj_walk) begin
                state_d = S_BACK_RD;
              end
            end else if (take_left) begin
              row_d = row_q + 1'b1;
            end else begin
              col_d = col_q - 1'b1;
            end
          end
        end
      end
      S_BACK_RD: begin
        state_d = S_BACK_EV;
      end
      S_BACK_EV: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_char = stk_rd_q;
          emit_end  = (sp_q == IW'(1));
          sp_d      = sp_q - 1'b1;
          if (sp_q == IW'(1)) begin
            state_d = S_LOAD;
            len_d   = '0;
            ovf_d   = 1'b0;
          end else begin
            state_d = S_BACK_RD;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    out_ins_d   = out_ins_q;
    out_end_d   = out_end_q;
    out_ovf_d   = out_ovf_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_char_d  = emit_char;
      out_ins_d   = ins_q;
      out_end_d   = emit_end;
      out_ovf_d   = ovf_q;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      len_q       <= '0;
      ovf_q       <= 1'b0;
      row_q       <= '0;
      col_q       <= '0;
      sp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      ovf_q       <= ovf_d;
      row_q       <= row_d;
      col_q       <= col_d;
      sp_q        <= sp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ins_q      <= ins_d;
    out_char_q <= out_char_d;
    out_ins_q  <= out_ins_d;
    out_end_q  <= out_end_d;
    out_ovf_q  <= out_ovf_d;
  end

  always_ff @(posedge clk_i) begin
    if (word_we) begin
      word_mem[len_q[IW-1:0]] <= char_in_i;
    end
    wa_q <= word_mem[row_q];
    wb_q <= word_mem[col_q];
    if (stk_we) begin
      stk_mem[sp_q] <= walk_char;
    end
    stk_rd_q <= stk_mem[sp_q - 1'b1];
  end

  assign out_valid_o    = out_valid_q;
  assign char_out_o     = out_char_q;
  assign insert_count_o = out_ins_q;
  assign run_end_o      = out_end_q;
  assign overflowed_o   = out_ovf_q;

  a_stack_in_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_LOAD) |-> ((len_q != '0) && (LW'(sp_q) < len_q)))
    else $error("mirror stack deeper than the stored word");

  a_fill_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FILL) |-> ((row_q < col_q) && (col_q <= n_last)))
    else $error("fill cell outside the upper triangle of the word");

  a_walk_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK_EV) |-> (row_q <= col_q))
    else $error("walk pointers crossed without ending the front half");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && emit_end) |=> ((state_q == S_LOAD) && (len_q == '0) && !ovf_q))
    else $error("last transaction of a word did not return to loading");

endmodule
